// ===== sv/mi3_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; used by mi3_div and matrix_inverse_3x3.
package mi3_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int NE           = 9;                    // matrix entries
    localparam int FRONT_STAGES = 8;                    // regs ahead of the divider

    localparam int PW  = 2 * DATA_WIDTH;                // entry product
    localparam int AW  = 2 * DATA_WIDTH + 1;            // signed cofactor
    localparam int NW  = 2 * DATA_WIDTH;                // cofactor magnitude
    localparam int PPW = 2 * DATA_WIDTH + 1;            // determinant partial product
    localparam int DW  = 3 * DATA_WIDTH + 3;            // signed determinant
    localparam int DMW = 3 * DATA_WIDTH;                // determinant magnitude
    localparam int QB  = DATA_WIDTH + 1;                // quotient bits kept
    localparam int XW  = ((2 * DATA_WIDTH + 2 * FRAC_BITS + 1 > 3 * DATA_WIDTH) ?
                          (2 * DATA_WIDTH + 2 * FRAC_BITS + 1) : (3 * DATA_WIDTH)) + 1;
    localparam int YW  = DMW + 1;                       // doubled divisor

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [XW-1:0] t_x;
    typedef logic [YW-1:0] t_y;
    typedef logic [QB-1:0] t_q;

    localparam t_q    LIM     = t_q'(1) << (DATA_WIDTH - 1);
    localparam t_data SAT_MAX = t_data'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
    localparam t_data SAT_MIN = t_data'(64'(1) << (DATA_WIDTH - 1));

    typedef struct packed {
        logic          singular;
        logic [NE-1:0] neg;
    } t_ctl;

    typedef struct packed {
        logic [NE-1:0][DATA_WIDTH-1:0] r;
        logic                          singular;
        logic                          saturated;
    } t_res;

endpackage

// ===== sv/mi3_div.sv =====
`timescale 1ns / 1ps
// Nine-lane restoring divider, one quotient bit per register stage.
// Depends on mi3_pkg.
module mi3_div
    import mi3_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_x            i_x [NE],
    input  t_y            i_y,
    input  t_ctl          i_ctl,
    output logic          o_valid,
    output t_q            o_q [NE],
    output logic [NE-1:0] o_big,
    output t_ctl          o_ctl
);

    logic [QB:0]   r_v;
    t_y            r_y   [QB+1];
    t_ctl          r_ctl [QB+1];
    logic [NE-1:0] r_big [QB+1];
    t_y            r_p   [QB+1][NE];
    t_q            r_xl  [QB+1][NE];
    t_q            r_q   [QB+1][NE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    // quotient of 2^QB or more means the entry saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < NE; e++) begin
                r_big[0][e] <= (i_x[e] >> QB) >= XW'(i_y);
                r_p[0][e]   <= YW'(i_x[e] >> QB);
                r_xl[0][e]  <= i_x[e][QB-1:0];
                r_q[0][e]   <= '0;
            end
            r_y[0]   <= i_y;
            r_ctl[0] <= i_ctl;
        end
    end

    for (genvar gs = 1; gs <= QB; gs++) begin : g_stage
        localparam int B = QB - gs;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_big[gs] <= r_big[gs-1];
                r_y[gs]   <= r_y[gs-1];
                r_ctl[gs] <= r_ctl[gs-1];
            end
        end

        for (genvar ge = 0; ge < NE; ge++) begin : g_lane
            logic [YW:0] w_pp;
            logic [YW:0] w_df;
            logic        w_ge;
            t_q          n_q;

            always_comb begin
                w_pp   = {r_p[gs-1][ge], r_xl[gs-1][ge][B]};
                w_df   = w_pp - {1'b0, r_y[gs-1]};
                w_ge   = w_pp >= {1'b0, r_y[gs-1]};
                n_q    = r_q[gs-1][ge];
                n_q[B] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[gs][ge]  <= w_ge ? w_df[YW-1:0] : w_pp[YW-1:0];
                    r_q[gs][ge]  <= n_q;
                    r_xl[gs][ge] <= r_xl[gs-1][ge];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_q     = r_q[QB];
    assign o_big   = r_big[QB];
    assign o_ctl   = r_ctl[QB];

endmodule

// ===== sv/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate: cofactors, determinant, rounded division.
// Depends on mi3_pkg and mi3_div.
//
// Input channel: i_valid / o_ready carry one matrix word (i_m00..i_m22, Q16.16).
// Output channel: o_valid / i_ready carry one inverse word (o_r00..o_r22),
// o_singular (zero determinant, entries all zero) and o_saturated (some entry
// clipped to the signed range). Entries are rounded to nearest, ties away
// from zero.
// Stages from the accepting edge to o_valid, in order:
// eight front stages (products, cofactors, determinant, magnitudes), one
// divider setup stage, one stage per quotient bit, then the output register.
// Throughput: one matrix per cycle while o_ready is high; the bit-per-stage divider sets the depth.
// Stalls: the whole pipeline moves together. When the receiver holds off, one
// more word drains into a skid register and then o_ready drops until the
// skid register empties. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties every stage and both output regs.
module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_data i_m00,
    input  t_data i_m01,
    input  t_data i_m02,
    input  t_data i_m10,
    input  t_data i_m11,
    input  t_data i_m12,
    input  t_data i_m20,
    input  t_data i_m21,
    input  t_data i_m22,
    output logic  o_valid,
    input  logic  i_ready,
    output t_data o_r00,
    output t_data o_r01,
    output t_data o_r02,
    output t_data o_r10,
    output t_data o_r11,
    output t_data o_r12,
    output t_data o_r20,
    output t_data o_r21,
    output t_data o_r22,
    output logic  o_singular,
    output logic  o_saturated
);

    logic                    w_en;
    logic [FRONT_STAGES-1:0] r_v;

    t_data                  r_m    [NE];
    t_data                  r_m01  [3];
    t_data                  r_m02  [3];
    logic signed [PW-1:0]   r_t    [NE];
    logic signed [PW-1:0]   r_u    [NE];
    logic signed [AW-1:0]   r_adj2 [NE];
    logic signed [AW-1:0]   r_adj3 [NE];
    logic signed [AW-1:0]   r_adj4 [NE];
    logic signed [AW-1:0]   r_adj5 [NE];
    logic signed [PPW-1:0]  r_plo  [3];
    logic signed [PPW-1:0]  r_phi  [3];
    logic signed [DW-1:0]   r_ps   [3];
    logic signed [DW-1:0]   r_det;
    logic [NW-1:0]          r_n    [NE];
    logic [DMW-1:0]         r_d;
    t_ctl                   r_ctl6;
    t_ctl                   r_ctl7;
    t_ctl                   n_ctl;
    t_x                     r_x    [NE];
    t_y                     r_y;

    logic          w_dv;
    t_q            w_q [NE];
    logic [NE-1:0] w_big;
    t_ctl          w_ctl;
    t_res          w_res;

    t_res r_out;
    t_res r_sk;
    logic r_out_v;
    logic r_sk_v;

    // pipeline advances unless the skid register is holding a word
    assign w_en    = !r_sk_v;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m[0] <= i_m00;  r_m[1] <= i_m01;  r_m[2] <= i_m02;
            r_m[3] <= i_m10;  r_m[4] <= i_m11;  r_m[5] <= i_m12;
            r_m[6] <= i_m20;  r_m[7] <= i_m21;  r_m[8] <= i_m22;
            for (int k = 0; k < 3; k++) begin
                r_m01[k] <= r_m[k];
                r_m02[k] <= r_m01[k];
            end
        end
    end

    // cofactor products, cyclic-index form, already transposed
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int E  = gi * 3 + gj;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_t[E]    <= r_m[J1*3+I1] * r_m[J2*3+I2];
                    r_u[E]    <= r_m[J1*3+I2] * r_m[J2*3+I1];
                    r_adj2[E] <= $signed({r_t[E][PW-1], r_t[E]})
                               - $signed({r_u[E][PW-1], r_u[E]});
                end
            end
        end
    end

    // determinant: first row times first adjugate column, cofactor split in two
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_plo[k] <= r_m02[k] * $signed({1'b0, r_adj2[k*3][DATA_WIDTH-1:0]});
                r_phi[k] <= r_m02[k] * $signed(r_adj2[k*3][AW-1:DATA_WIDTH]);
                r_ps[k]  <= ($signed({{(DW-PPW){r_phi[k][PPW-1]}}, r_phi[k]}) <<< DATA_WIDTH)
                          + $signed({{(DW-PPW){r_plo[k][PPW-1]}}, r_plo[k]});
            end
            r_det <= r_ps[0] + r_ps[1] + r_ps[2];
            for (int e = 0; e < NE; e++) begin
                r_adj3[e] <= r_adj2[e];
                r_adj4[e] <= r_adj3[e];
                r_adj5[e] <= r_adj4[e];
            end
        end
    end

    always_comb begin
        n_ctl.singular = (r_det == '0);
        for (int e = 0; e < NE; e++) begin
            n_ctl.neg[e] = r_adj5[e][AW-1] ^ r_det[DW-1];
        end
    end

    // magnitudes, then rounded dividend 2|adj|*2^(2F) + |det| over 2|det|
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < NE; e++) begin
                r_n[e] <= r_adj5[e][AW-1] ? NW'(-r_adj5[e]) : NW'(r_adj5[e]);
                r_x[e] <= (XW'(r_n[e]) << (2 * FRAC_BITS + 1)) + XW'(r_d);
            end
            r_d    <= r_det[DW-1] ? DMW'(-r_det) : DMW'(r_det);
            r_ctl6 <= n_ctl;
            r_y    <= {r_d, 1'b0};
            r_ctl7 <= r_ctl6;
        end
    end

    mi3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v[FRONT_STAGES-1]),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_ctl   (r_ctl7),
        .o_valid (w_dv),
        .o_q     (w_q),
        .o_big   (w_big),
        .o_ctl   (w_ctl)
    );

    // sign and saturation; negative side reaches one further
    always_comb begin
        w_res.singular  = w_ctl.singular;
        w_res.saturated = 1'b0;
        for (int e = 0; e < NE; e++) begin
            if (w_ctl.singular) begin
                w_res.r[e] = '0;
            end else if (!w_ctl.neg[e]) begin
                if (w_big[e] || w_q[e] >= LIM) begin
                    w_res.r[e]      = SAT_MAX;
                    w_res.saturated = 1'b1;
                end else begin
                    w_res.r[e] = w_q[e][DATA_WIDTH-1:0];
                end
            end else begin
                if (w_big[e] || w_q[e] > LIM) begin
                    w_res.r[e]      = SAT_MIN;
                    w_res.saturated = 1'b1;
                end else begin
                    w_res.r[e] = ~w_q[e][DATA_WIDTH-1:0] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (i_ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (w_dv) begin
            if (r_out_v && !i_ready) begin
                r_sk_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (i_ready) begin
                r_out <= r_sk;
            end
        end else if (w_dv) begin
            if (r_out_v && !i_ready) begin
                r_sk <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_r00       = r_out.r[0];
    assign o_r01       = r_out.r[1];
    assign o_r02       = r_out.r[2];
    assign o_r10       = r_out.r[3];
    assign o_r11       = r_out.r[4];
    assign o_r12       = r_out.r[5];
    assign o_r20       = r_out.r[6];
    assign o_r21       = r_out.r[7];
    assign o_r22       = r_out.r[8];
    assign o_singular  = r_out.singular;
    assign o_saturated = r_out.saturated;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid word held with output register empty");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.singular) |-> (!r_out.saturated && r_out.r == '0))
        else $error("singular word carries entries or saturation");

    a_drain_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv && !r_sk_v && r_out_v && !i_ready) |=> r_sk_v)
        else $error("divider word lost while output stalled");

    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && i_ready) |=> o_ready)
        else $error("pipeline did not resume after skid drained");
`endif

endmodule
